### sv/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned PHASE_W     = 16;
   localparam int unsigned POLL_W      = 8;
   localparam int unsigned BIT_IDX_W   = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_POLL    = 1'b1;

   localparam logic [PHASE_W-1:0] HALF_PERIOD_RESET = 16'd10;
   localparam logic [POLL_W-1:0]  ACK_POLL_RESET    = 8'd100;

   localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [2:0] {
      KIND_TICK  = 3'd0,
      KIND_START = 3'd1,
      KIND_STOP  = 3'd2,
      KIND_WRITE = 3'd3,
      KIND_READ  = 3'd4
   } kind_type;

   typedef enum logic [25:0] {
      ST_IDLE    = 26'h0000001,
      ST_STA_A   = 26'h0000002,
      ST_STA_B   = 26'h0000004,
      ST_STA_C   = 26'h0000008,
      ST_STA_D   = 26'h0000010,
      ST_STO_A   = 26'h0000020,
      ST_STO_B   = 26'h0000040,
      ST_STO_C   = 26'h0000080,
      ST_STO_D   = 26'h0000100,
      ST_WR_PRE  = 26'h0000200,
      ST_WR_DATA = 26'h0000400,
      ST_WR_HIGH = 26'h0000800,
      ST_WR_LOW  = 26'h0001000,
      ST_WR_ZERO = 26'h0002000,
      ST_WR_REL  = 26'h0004000,
      ST_WR_ACK  = 26'h0008000,
      ST_WR_END  = 26'h0010000,
      ST_RD_REL1 = 26'h0020000,
      ST_RD_REL2 = 26'h0040000,
      ST_RD_HIGH = 26'h0080000,
      ST_RD_LOW  = 26'h0100000,
      ST_RD_DRV1 = 26'h0200000,
      ST_RD_DRV2 = 26'h0400000,
      ST_RD_ACKD = 26'h0800000,
      ST_RD_ACKH = 26'h1000000,
      ST_RD_END  = 26'h2000000
   } state_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] write_byte;
      logic       final_nack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       no_ack;
      logic       rejected;
   } rsp_type;

   typedef struct packed {
      logic [PHASE_W-1:0] half_period_ticks;
      logic [POLL_W-1:0]  ack_poll_ticks;
   } cfg_type;

endpackage

### sv/i2cm_seq.sv
// Line sequencer: state registers and the one-word step logic.
module i2cm_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  i2cm_pkg::req_type item,
   input  i2cm_pkg::cfg_type cfg,
   output i2cm_pkg::rsp_type result
);
   import i2cm_pkg::*;

   state_type              state_ff, state_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [BIT_IDX_W-1:0]   bit_idx_ff, bit_idx_in;
   logic [7:0]             shift_ff, shift_in;
   logic                   nack_ff, nack_in;
   logic                   ack_seen_ff, ack_seen_in;
   logic                   scl_ff, scl_in;
   logic                   sda_ff, sda_in;
   logic                   drive_ff, drive_in;
   logic [PHASE_W-1:0]     half_eff;
   logic [PHASE_W-1:0]     poll_eff;

   assign half_eff = (cfg.half_period_ticks == '0) ? PHASE_W'(1) : cfg.half_period_ticks;
   assign poll_eff = (cfg.ack_poll_ticks == '0) ? PHASE_W'(1)
                                                : {{(PHASE_W-POLL_W){1'b0}}, cfg.ack_poll_ticks};

   always_comb begin
      logic do_adv;
      logic fin_done;
      logic fin_noack;
      logic [7:0] fin_read;
      logic rej;
      state_in    = state_ff;
      phase_in    = phase_ff;
      bit_idx_in  = bit_idx_ff;
      shift_in    = shift_ff;
      nack_in     = nack_ff;
      ack_seen_in = ack_seen_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      drive_in    = drive_ff;
      do_adv      = 1'b0;
      fin_done    = 1'b0;
      fin_noack   = 1'b0;
      fin_read    = 8'd0;
      rej         = 1'b0;

      if (item.kind == KIND_TICK) begin
         if (state_ff != ST_IDLE) begin
            if (state_ff == ST_WR_ACK && !item.sda_in) begin
               ack_seen_in = 1'b1;
               do_adv      = 1'b1;
            end else if (phase_ff > PHASE_W'(1)) begin
               phase_in = phase_ff - PHASE_W'(1);
            end else begin
               do_adv = 1'b1;
            end
         end
      end else if (item.kind inside {KIND_START, KIND_STOP, KIND_WRITE, KIND_READ}) begin
         if (state_ff != ST_IDLE) begin
            rej = 1'b1;
         end else begin
            phase_in = half_eff;
            case (item.kind)
               KIND_START: begin
                  drive_in = 1'b1;
                  sda_in   = 1'b1;
                  state_in = ST_STA_A;
               end
               KIND_STOP: begin
                  drive_in = 1'b1;
                  scl_in   = 1'b0;
                  state_in = ST_STO_A;
               end
               KIND_WRITE: begin
                  drive_in    = 1'b1;
                  scl_in      = 1'b0;
                  shift_in    = item.write_byte;
                  bit_idx_in  = '0;
                  ack_seen_in = 1'b0;
                  state_in    = ST_WR_PRE;
               end
               default: begin
                  drive_in   = 1'b0;
                  shift_in   = 8'd0;
                  bit_idx_in = '0;
                  nack_in    = item.final_nack;
                  state_in   = ST_RD_REL1;
               end
            endcase
         end
      end

      if (do_adv) begin
         phase_in = half_eff;
         case (state_ff)
            ST_STA_A: begin scl_in = 1'b1; state_in = ST_STA_B; end
            ST_STA_B: begin sda_in = 1'b0; state_in = ST_STA_C; end
            ST_STA_C: begin scl_in = 1'b0; state_in = ST_STA_D; end
            ST_STO_A: begin sda_in = 1'b0; state_in = ST_STO_B; end
            ST_STO_B: begin scl_in = 1'b1; state_in = ST_STO_C; end
            ST_STO_C: begin sda_in = 1'b1; state_in = ST_STO_D; end
            ST_STO_D: begin
               scl_in   = 1'b0;
               sda_in   = 1'b0;
               state_in = ST_IDLE;
               phase_in = '0;
               fin_done = 1'b1;
            end
            ST_WR_DATA: begin scl_in = 1'b1; state_in = ST_WR_HIGH; end
            ST_WR_HIGH: begin
               scl_in     = 1'b0;
               bit_idx_in = bit_idx_ff + BIT_IDX_W'(1);
               state_in   = ST_WR_LOW;
            end
            ST_WR_PRE, ST_WR_LOW: begin
               if (state_ff == ST_WR_PRE || bit_idx_ff < BITS_PER_BYTE) begin
                  sda_in   = shift_ff[7];
                  shift_in = {shift_ff[6:0], 1'b0};
                  state_in = ST_WR_DATA;
               end else begin
                  sda_in   = 1'b0;
                  state_in = ST_WR_ZERO;
               end
            end
            ST_WR_ZERO: begin drive_in = 1'b0; state_in = ST_WR_REL; end
            ST_WR_REL: begin
               scl_in   = 1'b1;
               state_in = ST_WR_ACK;
               phase_in = poll_eff;
            end
            ST_WR_ACK: begin scl_in = 1'b0; state_in = ST_WR_END; end
            ST_WR_END: begin
               drive_in  = 1'b1;
               sda_in    = 1'b1;
               fin_noack = !ack_seen_ff;
               state_in  = ST_IDLE;
               phase_in  = '0;
               fin_done  = 1'b1;
            end
            ST_RD_REL1: state_in = ST_RD_REL2;
            ST_RD_REL2: begin scl_in = 1'b1; state_in = ST_RD_HIGH; end
            ST_RD_HIGH: begin
               shift_in   = {shift_ff[6:0], item.sda_in};
               scl_in     = 1'b0;
               bit_idx_in = bit_idx_ff + BIT_IDX_W'(1);
               state_in   = ST_RD_LOW;
            end
            ST_RD_LOW: begin
               if (bit_idx_ff < BITS_PER_BYTE) begin
                  scl_in   = 1'b1;
                  state_in = ST_RD_HIGH;
               end else begin
                  drive_in = 1'b1;
                  state_in = ST_RD_DRV1;
               end
            end
            ST_RD_DRV1: state_in = ST_RD_DRV2;
            ST_RD_DRV2: begin sda_in = nack_ff; state_in = ST_RD_ACKD; end
            ST_RD_ACKD: begin scl_in = 1'b1; state_in = ST_RD_ACKH; end
            ST_RD_ACKH: begin scl_in = 1'b0; state_in = ST_RD_END; end
            ST_RD_END: begin
               fin_read = shift_ff;
               state_in = ST_IDLE;
               phase_in = '0;
               fin_done = 1'b1;
            end
            ST_STA_D: begin
               state_in = ST_IDLE;
               phase_in = '0;
               fin_done = 1'b1;
            end
            default: begin
               state_in = ST_IDLE;
               phase_in = '0;
            end
         endcase
      end

      result.scl_level = scl_in;
      result.sda_level = sda_in;
      result.sda_drive = drive_in;
      result.busy_res  = (state_in != ST_IDLE);
      result.done_res  = fin_done;
      result.read_byte = fin_read;
      result.no_ack    = fin_noack;
      result.rejected  = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= '0;
         bit_idx_ff  <= '0;
         shift_ff    <= 8'd0;
         nack_ff     <= 1'b0;
         ack_seen_ff <= 1'b0;
         scl_ff      <= 1'b0;
         sda_ff      <= 1'b1;
         drive_ff    <= 1'b1;
      end else if (step_en) begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         bit_idx_ff  <= bit_idx_in;
         shift_ff    <= shift_in;
         nack_ff     <= nack_in;
         ack_seen_ff <= ack_seen_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_in;
         drive_ff    <= drive_in;
      end
   end

endmodule

### sv/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: channels, registers and sequencer.
//
//   Port group   Direction   Handshake             Word
//   req_         in          req_valid/req_stall   command or tick with sampled SDA
//   rsp_         out         rsp_valid/rsp_stall   pin levels, done, read data, status
//   csr_         in          csr_wr_en             register index and data
//
// One word is accepted per clock while req_stall is low; each produces one result,
// after the input register and the result register.
// The sequencer state advances in the cycle a word moves from the input
// register into the result register.
// Reset empties both registers, resets the sequencer and presets the CSRs.
// A stalled result holds its register; the input side stalls only when the input
// register is full and the result cannot move.
module i2c_master_bit_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  i2cm_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output i2cm_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [i2cm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0]       csr_wr_data
);
   import i2cm_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   cfg_type cfg_ff;
   rsp_type step_result;
   logic    out_free;
   logic    step_en;
   logic    req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (step_en ? 1'b0 : in_valid_ff);
   assign out_valid_in = step_en ? 1'b1 : ((out_valid_ff && !rsp_stall) ? 1'b0 : out_valid_ff);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (step_en) begin
         out_data_ff <= step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks <= HALF_PERIOD_RESET;
         cfg_ff.ack_poll_ticks    <= ACK_POLL_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HALF_PERIOD: cfg_ff.half_period_ticks <= csr_wr_data[PHASE_W-1:0];
            CSR_ACK_POLL:    cfg_ff.ack_poll_ticks    <= csr_wr_data[POLL_W-1:0];
            default: ;
         endcase
      end
   end

   i2cm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_data_ff),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   a_done_not_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.done_res && rsp_data.busy_res))
      else $error("done and busy reported together");

   a_reject_busy : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.rejected) |-> rsp_data.busy_res)
      else $error("rejected word while sequencer idle");

   a_noack_done : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.no_ack) |-> rsp_data.done_res)
      else $error("no_ack without a finished write");

   a_step_fills_out : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !(rsp_valid && rsp_stall)) |=> rsp_valid)
      else $error("stepped word did not reach the result register");

endmodule

### dv/i2cm_checker.sv
// Checker for the I2C master bit engine: predicts each result word and compares it.
`timescale 1ns / 100ps

module i2cm_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  i2cm_pkg::req_type                   req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  i2cm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [i2cm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   output int unsigned                         words_owed,
   output logic                                line_busy,
   output int unsigned                         fail_count
);
   import i2cm_pkg::*;

   state_type          seq_state;
   logic [PHASE_W-1:0] phase_left;
   logic [PHASE_W-1:0] half_cfg;
   logic [POLL_W-1:0]  poll_cfg;
   logic [7:0]         shreg;
   logic [3:0]         bit_cnt;
   logic               nack_q;
   logic               ack_hit;
   logic               scl_q;
   logic               sda_q;
   logic               drv_q;
   logic               done_now;
   logic               noack_now;
   logic [7:0]         rd_now;
   rsp_type            expected_words[$];

   function automatic void enter_phase(state_type s);
      seq_state = s;
      phase_left = (half_cfg == '0) ? 16'd1 : half_cfg;
   endfunction

   function automatic void end_sequence();
      seq_state = ST_IDLE;
      phase_left = '0;
      done_now = 1'b1;
   endfunction

   function automatic void shift_out_bit();
      sda_q = shreg[7];
      shreg = {shreg[6:0], 1'b0};
      enter_phase(ST_WR_DATA);
   endfunction

   function automatic void step_line(logic sda);
      case (seq_state)
         ST_STA_A: begin scl_q = 1'b1; enter_phase(ST_STA_B); end
         ST_STA_B: begin sda_q = 1'b0; enter_phase(ST_STA_C); end
         ST_STA_C: begin scl_q = 1'b0; enter_phase(ST_STA_D); end
         ST_STA_D: end_sequence();
         ST_STO_A: begin sda_q = 1'b0; enter_phase(ST_STO_B); end
         ST_STO_B: begin scl_q = 1'b1; enter_phase(ST_STO_C); end
         ST_STO_C: begin sda_q = 1'b1; enter_phase(ST_STO_D); end
         ST_STO_D: begin
            scl_q = 1'b0;
            sda_q = 1'b0;
            end_sequence();
         end
         ST_WR_PRE: shift_out_bit();
         ST_WR_DATA: begin scl_q = 1'b1; enter_phase(ST_WR_HIGH); end
         ST_WR_HIGH: begin
            scl_q = 1'b0;
            bit_cnt = bit_cnt + 4'd1;
            enter_phase(ST_WR_LOW);
         end
         ST_WR_LOW: begin
            if (bit_cnt < BITS_PER_BYTE) begin
               shift_out_bit();
            end else begin
               sda_q = 1'b0;
               enter_phase(ST_WR_ZERO);
            end
         end
         ST_WR_ZERO: begin drv_q = 1'b0; enter_phase(ST_WR_REL); end
         ST_WR_REL: begin
            scl_q = 1'b1;
            seq_state = ST_WR_ACK;
            phase_left = (poll_cfg == '0) ? 16'd1 : {8'h00, poll_cfg};
         end
         ST_WR_ACK: begin scl_q = 1'b0; enter_phase(ST_WR_END); end
         ST_WR_END: begin
            drv_q = 1'b1;
            sda_q = 1'b1;
            noack_now = !ack_hit;
            end_sequence();
         end
         ST_RD_REL1: enter_phase(ST_RD_REL2);
         ST_RD_REL2: begin scl_q = 1'b1; enter_phase(ST_RD_HIGH); end
         ST_RD_HIGH: begin
            shreg = {shreg[6:0], sda};
            scl_q = 1'b0;
            bit_cnt = bit_cnt + 4'd1;
            enter_phase(ST_RD_LOW);
         end
         ST_RD_LOW: begin
            if (bit_cnt < BITS_PER_BYTE) begin
               scl_q = 1'b1;
               enter_phase(ST_RD_HIGH);
            end else begin
               drv_q = 1'b1;
               enter_phase(ST_RD_DRV1);
            end
         end
         ST_RD_DRV1: enter_phase(ST_RD_DRV2);
         ST_RD_DRV2: begin sda_q = nack_q; enter_phase(ST_RD_ACKD); end
         ST_RD_ACKD: begin scl_q = 1'b1; enter_phase(ST_RD_ACKH); end
         ST_RD_ACKH: begin scl_q = 1'b0; enter_phase(ST_RD_END); end
         ST_RD_END: begin rd_now = shreg; end_sequence(); end
         default: begin
            seq_state = ST_IDLE;
            phase_left = '0;
         end
      endcase
   endfunction

   function automatic rsp_type line_result(req_type w);
      rsp_type r;
      r = '0;
      done_now = 1'b0;
      noack_now = 1'b0;
      rd_now = '0;
      case (w.kind)
         KIND_TICK: begin
            if (seq_state != ST_IDLE) begin
               if (seq_state == ST_WR_ACK && !w.sda_in) begin
                  ack_hit = 1'b1;
                  step_line(w.sda_in);
               end else if (phase_left > 16'd1) begin
                  phase_left = phase_left - 16'd1;
               end else begin
                  step_line(w.sda_in);
               end
            end
         end
         KIND_START, KIND_STOP, KIND_WRITE, KIND_READ: begin
            if (seq_state != ST_IDLE) begin
               r.rejected = 1'b1;
            end else begin
               case (w.kind)
                  KIND_START: begin
                     drv_q = 1'b1;
                     sda_q = 1'b1;
                     enter_phase(ST_STA_A);
                  end
                  KIND_STOP: begin
                     drv_q = 1'b1;
                     scl_q = 1'b0;
                     enter_phase(ST_STO_A);
                  end
                  KIND_WRITE: begin
                     drv_q = 1'b1;
                     scl_q = 1'b0;
                     shreg = w.write_byte;
                     bit_cnt = '0;
                     ack_hit = 1'b0;
                     enter_phase(ST_WR_PRE);
                  end
                  default: begin
                     drv_q = 1'b0;
                     shreg = '0;
                     bit_cnt = '0;
                     nack_q = w.final_nack;
                     enter_phase(ST_RD_REL1);
                  end
               endcase
            end
         end
         default: ;
      endcase
      r.scl_level = scl_q;
      r.sda_level = sda_q;
      r.sda_drive = drv_q;
      r.busy_res = (seq_state != ST_IDLE);
      r.done_res = done_now;
      r.read_byte = rd_now;
      r.no_ack = noack_now;
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         half_cfg = HALF_PERIOD_RESET;
         poll_cfg = ACK_POLL_RESET;
         seq_state = ST_IDLE;
         phase_left = '0;
         bit_cnt = '0;
         shreg = '0;
         nack_q = 1'b0;
         ack_hit = 1'b0;
         scl_q = 1'b0;
         sda_q = 1'b1;
         drv_q = 1'b1;
         fail_count = 0;
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("result word %h arrived with nothing expected", rsp_data);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("scl_level", 8'(want.scl_level), 8'(rsp_data.scl_level));
               check_field("sda_level", 8'(want.sda_level), 8'(rsp_data.sda_level));
               check_field("sda_drive", 8'(want.sda_drive), 8'(rsp_data.sda_drive));
               check_field("busy_res", 8'(want.busy_res), 8'(rsp_data.busy_res));
               check_field("done_res", 8'(want.done_res), 8'(rsp_data.done_res));
               check_field("read_byte", want.read_byte, rsp_data.read_byte);
               check_field("no_ack", 8'(want.no_ack), 8'(rsp_data.no_ack));
               check_field("rejected", 8'(want.rejected), 8'(rsp_data.rejected));
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_HALF_PERIOD: half_cfg = csr_wr_data[PHASE_W-1:0];
               CSR_ACK_POLL: poll_cfg = csr_wr_data[POLL_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_words.push_back(line_result(req_data));
      end
      words_owed <= expected_words.size();
      line_busy <= (seq_state != ST_IDLE);
   end

endmodule

### dv/tb.sv
// Testbench top for the I2C master bit engine: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
   import i2cm_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   int unsigned words_owed;
   logic        line_busy;
   int unsigned fail_count;

   bit          idle_on = 1'b1;
   bit          stall_on = 1'b1;
   int          burst_left = 0;
   int          stall_left = 0;
   int          stall_mode = 0;
   int unsigned words_sent = 0;

   i2c_master_bit_engine dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   i2cm_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data),
      .words_owed(words_owed),
      .line_busy(line_busy),
      .fail_count(fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || !stall_on) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(3, 30);
         rsp_stall <= 1'b0;
      end else begin
         stall_left <= stall_left - 1;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= 1'b1;
         endcase
      end
   end

   function automatic req_type make_word(logic [2:0] kind, logic [7:0] wb, logic fn,
                                         logic sda);
      req_type w;
      w.kind = kind;
      w.write_byte = wb;
      w.final_nack = fn;
      w.sda_in = sda;
      return w;
   endfunction

   task automatic send_word(input req_type w);
      if (idle_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_data <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left > 0) burst_left--;
      if (w.kind <= KIND_READ) words_sent++;
   endtask

   // Issues one command, then ticks until the sequence it started is over.
   // A noisy run mixes in commands and undefined kinds while busy.
   task automatic run_cmd(input logic [2:0] kind, input logic [7:0] wb, input logic fn,
                          input int p_low, input bit noisy);
      send_word(make_word(kind, wb, fn, 1'b1));
      do begin
         if (noisy && $urandom_range(0, 99) < 4)
            send_word(make_word(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom),
                                1'($urandom)));
         else
            send_word(make_word(KIND_TICK, 8'($urandom), 1'($urandom),
                                $urandom_range(0, 99) >= p_low));
      end while (line_busy);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0 || line_busy) begin
         if (words_owed == 0) begin
            send_word(make_word(KIND_TICK, 8'h00, 1'b0, 1'b1));
            req_valid <= 1'b0;
         end
         @(posedge clock);
      end
   endtask

   task automatic set_line_config(input logic [CSR_DATA_W-1:0] half,
                                  input logic [CSR_DATA_W-1:0] poll);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_HALF_PERIOD;
      csr_wr_data <= half;
      @(posedge clock);
      csr_index <= CSR_ACK_POLL;
      csr_wr_data <= poll;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] half;
      logic [7:0]            poll;
      int unsigned           mark;
      int                    pick;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_cmd(KIND_TICK, 8'h00, 1'b0, 0, 1'b0);
      run_cmd(KIND_START, 8'h00, 1'b0, 50, 1'b0);
      run_cmd(3'd5, 8'hFF, 1'b1, 0, 1'b0);
      run_cmd(3'd7, 8'h00, 1'b0, 100, 1'b0);

      settle();
      set_line_config(16'd1, 16'd2);
      run_cmd(KIND_WRITE, 8'hFF, 1'b0, 0, 1'b0);
      run_cmd(KIND_WRITE, 8'h00, 1'b0, 100, 1'b0);
      run_cmd(KIND_READ, 8'h00, 1'b0, 0, 1'b0);
      run_cmd(KIND_READ, 8'hFF, 1'b1, 100, 1'b0);
      send_word(make_word(KIND_STOP, 8'h00, 1'b0, 1'b1));
      run_cmd(KIND_WRITE, 8'hA5, 1'b1, 50, 1'b1);
      run_cmd(KIND_READ, 8'h3C, 1'b0, 50, 1'b1);

      settle();
      set_line_config(16'h0000, 16'hFF00);
      run_cmd(KIND_WRITE, 8'h5A, 1'b0, 0, 1'b0);
      run_cmd(KIND_READ, 8'h00, 1'b1, 50, 1'b0);

      settle();
      set_line_config(16'd1, 16'd255);
      run_cmd(KIND_WRITE, 8'h81, 1'b1, 0, 1'b0);

      settle();
      idle_on = 1'b0;
      stall_on = 1'b0;
      set_line_config(16'd40, 16'h0001);
      run_cmd(KIND_START, 8'h00, 1'b0, 50, 1'b0);
      settle();
      idle_on = 1'b1;
      stall_on = 1'b1;

      mark = words_sent;
      while (words_sent - mark < 1000) begin
         settle();
         pick = $urandom_range(0, 9);
         if (pick == 0) half = 16'd0;
         else if (pick <= 6) half = 16'd1;
         else if (pick <= 8) half = 16'($urandom_range(2, 4));
         else half = 16'($urandom_range(5, 12));
         pick = $urandom_range(0, 19);
         if (pick == 0) poll = 8'd0;
         else if (pick == 1) poll = 8'($urandom_range(5, 255));
         else poll = 8'($urandom_range(1, 4));
         set_line_config(half, {8'($urandom), poll});
         repeat ($urandom_range(2, 6))
            run_cmd(3'($urandom_range(1, 4)), 8'($urandom), 1'($urandom),
                    33 * $urandom_range(0, 3), 1'b1);
      end

      settle();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && words_owed == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   initial begin
      #50000000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
